// File: rtl/core/phe_pkg.sv
// ----------------------------------------------------------------------------
// phe_pkg
// Shared types and constants for the Paley type-I Hadamard entry generator.
// ----------------------------------------------------------------------------
package phe_pkg;

	localparam int MAX_ORDER = 1024;
	localparam int ORDER_W   = 11;
	localparam int IDX_W     = 10;
	localparam int ADDR_W    = $clog2(MAX_ORDER);

	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);
	localparam logic [ORDER_W-1:0] ORDER_MAX   = ORDER_W'(MAX_ORDER);

	localparam logic signed [1:0] VAL_POS  = 2'sb01;
	localparam logic signed [1:0] VAL_NEG  = 2'sb11;
	localparam logic signed [1:0] VAL_NONE = 2'sb00;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
	} req_t;

	typedef struct packed {
		logic signed [1:0] entry_value;
		logic              index_error;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic build_init;
		logic clear_en;
		logic mark_en;
		logic load_s1;
		logic load_out;
	} phe_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_table;
		logic clear_last;
		logic mark_last;
		logic mark_none;
	} phe_sts_t;

endpackage

// File: rtl/core/phe_ctrl.sv
// ----------------------------------------------------------------------------
// phe_ctrl
// Sequencer for the table build and handshake control for the request and
// response channels.
// ----------------------------------------------------------------------------
module phe_ctrl
	import phe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  logic     cfg_we,
	input  phe_sts_t sts,
	output phe_cmd_t cmd
);

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_MARK  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       table_ready_q;
	logic       table_ready_d;
	logic       valid_s1;
	logic       out_valid_q;
	logic       start_build;
	logic       accept;
	logic       move_out;

	assign start_build = (state_q == ST_RUN) && req_valid && sts.need_table && !table_ready_q;
	assign move_out    = valid_s1 && (!out_valid_q || rsp_ready);
	assign req_ready   = (state_q == ST_RUN) && !(sts.need_table && !table_ready_q) &&
	                     (!valid_s1 || move_out);
	assign accept      = req_valid && req_ready;
	assign rsp_valid   = out_valid_q;

	always_comb begin
		state_d       = state_q;
		table_ready_d = table_ready_q;
		cmd           = '0;
		cmd.load_s1   = accept;
		cmd.load_out  = move_out;
		case (state_q)
			ST_RUN: begin
				if (start_build) begin
					cmd.build_init = 1'b1;
					state_d        = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					if (sts.mark_none) begin
						state_d       = ST_RUN;
						table_ready_d = 1'b1;
					end else begin
						state_d = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				cmd.mark_en = 1'b1;
				if (sts.mark_last) begin
					state_d       = ST_RUN;
					table_ready_d = 1'b1;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
		// new order invalidates the table
		if (cfg_we)
			table_ready_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_RUN;
			table_ready_q <= 1'b0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			table_ready_q <= table_ready_d;
			if (accept)
				valid_s1 <= 1'b1;
			else if (move_out)
				valid_s1 <= 1'b0;
			if (move_out)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/phe_dp.sv
// ----------------------------------------------------------------------------
// phe_dp
// Order register, residue table with its build counters, lookup stage and
// response register.
// ----------------------------------------------------------------------------
module phe_dp
	import phe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [ORDER_W-1:0] cfg_wdata,
	input  req_t               req,
	output rsp_t               rsp,
	input  phe_cmd_t           cmd,
	output phe_sts_t           sts
);

	logic [ORDER_W-1:0] order_q;
	logic [ORDER_W-1:0] n_eff;
	logic [ADDR_W-1:0]  p;
	logic [ADDR_W-1:0]  half;
	logic [ADDR_W-1:0]  cnt_q;
	logic [ADDR_W-1:0]  i_q;
	logic [ADDR_W-1:0]  sq_q;
	logic [ADDR_W-1:0]  odd_q;
	logic [ADDR_W:0]    sq_sum;
	logic [ADDR_W-1:0]  sq_next;
	logic               idx_err;
	logic               edge_pos;
	logic [ADDR_W-1:0]  diff;
	logic [ADDR_W-1:0]  rd_addr;
	logic               mem [MAX_ORDER];
	logic               rd_s1;
	logic               err_s1;
	logic               pos_s1;
	logic               zero_s1;
	rsp_t               out_q;

	assign n_eff = (order_q > ORDER_MAX) ? ORDER_MAX : order_q;
	assign p     = ADDR_W'(n_eff - ORDER_W'(1));
	assign half  = (p - ADDR_W'(1)) >> 1;

	assign idx_err  = ({1'b0, req.row_index} >= n_eff) || ({1'b0, req.col_index} >= n_eff);
	assign edge_pos = (req.row_index == '0) || (req.col_index == '0);
	assign diff     = ADDR_W'(req.col_index) - ADDR_W'(req.row_index);
	// (c - r) mod p with 1 <= r,c <= p
	assign rd_addr  = (req.col_index >= req.row_index) ? diff : diff + p;

	// incremental square: (i+1)^2 = i^2 + (2i+1), reduced once mod p
	assign sq_sum  = {1'b0, sq_q} + {1'b0, odd_q};
	assign sq_next = (sq_sum >= {1'b0, p}) ? ADDR_W'(sq_sum - {1'b0, p}) : ADDR_W'(sq_sum);

	assign sts.need_table = !idx_err && !edge_pos;
	assign sts.clear_last = (cnt_q == p - ADDR_W'(1));
	assign sts.mark_last  = (i_q == half);
	assign sts.mark_none  = (half == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			order_q <= ORDER_RESET;
		else if (cfg_we)
			order_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.build_init) begin
			cnt_q <= '0;
			i_q   <= ADDR_W'(1);
			sq_q  <= ADDR_W'(1);
			odd_q <= ADDR_W'(3);
		end else begin
			if (cmd.clear_en)
				cnt_q <= cnt_q + ADDR_W'(1);
			if (cmd.mark_en) begin
				i_q   <= i_q + ADDR_W'(1);
				sq_q  <= sq_next;
				odd_q <= odd_q + ADDR_W'(2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en)
			mem[cnt_q] <= 1'b0;
		else if (cmd.mark_en)
			mem[sq_q] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			rd_s1   <= mem[rd_addr];
			err_s1  <= idx_err;
			pos_s1  <= edge_pos;
			zero_s1 <= (rd_addr == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.index_error <= err_s1;
			if (err_s1)
				out_q.entry_value <= VAL_NONE;
			else if (pos_s1 || (!zero_s1 && rd_s1))
				out_q.entry_value <= VAL_POS;
			else
				out_q.entry_value <= VAL_NEG;
		end
	end

	assign rsp = out_q;

endmodule

// File: rtl/core/paley_hadamard_entry_generator.sv
// ----------------------------------------------------------------------------
// paley_hadamard_entry_generator
// Entries of the normalized Paley type-I Hadamard matrix of order n.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_wdata load the order n (reset value 4); write only while idle.
//   Each request on req (valid/ready) carries a row and column index; one
//   response on rsp (valid/ready) returns +1/-1, or 0 with index_error set
//   when an index is not below n (orders above 1024 act as 1024).
//   rsp_valid rises once an accepted request has passed the table read stage
//   and the response register. While rsp_ready stays high and no table build
//   is pending, one request per cycle is sustained: the read stage and the
//   response register let a new request in while a response waits.
//   The first request that needs the residue table after reset or an order
//   write stalls req_ready for the build: a start step, then clearing the p
//   table entries and marking the squares of 1 to (p-1)/2, p = n-1, one
//   table write per cycle.
//   Requests on row 0 or column 0, and out-of-range ones, never need it.
//   Reset drops both valids and marks the table stale. When the receiver
//   stalls, the response holds and one more request can still be taken.
// ----------------------------------------------------------------------------
module paley_hadamard_entry_generator
	import phe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [ORDER_W-1:0] cfg_wdata
);

	phe_cmd_t cmd;
	phe_sts_t sts;

	phe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_we    (cfg_we),
		.sts       (sts),
		.cmd       (cmd)
	);

	phe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: rtl/core/phe_checker.sv
// ----------------------------------------------------------------------------
// phe_checker
// Port-level checks for the Hadamard entry generator, bound to the top level.
// ----------------------------------------------------------------------------
module phe_checker
	import phe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(rsp_ready))
		else $error("response dropped without being taken");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.index_error |-> rsp.entry_value == VAL_NONE)
		else $error("index error with nonzero entry");

	a_ok_sign: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.index_error |->
			rsp.entry_value == VAL_POS || rsp.entry_value == VAL_NEG)
		else $error("entry not +1 or -1");

endmodule

bind paley_hadamard_entry_generator phe_checker u_phe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: dv/tb_paley_hadamard_entry_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paley_hadamard_entry_generator
// Self-checking bench for the Paley type-I Hadamard entry generator.
// A short table of directed requests covers the index extremes, orders zero,
// one, two, three and above the maximum, row and column zero, the diagonal
// and the index error. Random segments then follow, one per order setting,
// under changing sender and receiver idling. Every response is compared with
// a known answer or an in-bench model of the quadratic residue rule.
// ----------------------------------------------------------------------------
module tb_paley_hadamard_entry_generator;
	import phe_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 300;
	localparam int N_SEGMENTS     = 14;
	localparam int SEG_ITEMS      = 50;
	localparam int N_PROBES       = 22;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	typedef struct packed {
		logic [ORDER_W-1:0] order;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		bit                 typed;
		logic signed [1:0]  value;
		logic               err;
	} probe_t;

	// typed rows carry a known answer; the rest go through the residue model
	localparam probe_t PROBES [N_PROBES] = '{
		'{11'd4,    10'd0,    10'd0,    1'b1, VAL_POS,  1'b0},
		'{11'd4,    10'd3,    10'd3,    1'b1, VAL_NEG,  1'b0},
		'{11'd4,    10'd1,    10'd2,    1'b0, VAL_NONE, 1'b0},
		'{11'd4,    10'd2,    10'd1,    1'b0, VAL_NONE, 1'b0},
		'{11'd4,    10'd4,    10'd0,    1'b1, VAL_NONE, 1'b1},
		'{11'd4,    10'd0,    10'd4,    1'b1, VAL_NONE, 1'b1},
		'{11'd4,    10'd1023, 10'd1023, 1'b1, VAL_NONE, 1'b1},
		'{11'd0,    10'd0,    10'd0,    1'b1, VAL_NONE, 1'b1},
		'{11'd1,    10'd0,    10'd0,    1'b1, VAL_POS,  1'b0},
		'{11'd1,    10'd0,    10'd1,    1'b1, VAL_NONE, 1'b1},
		'{11'd1,    10'd1,    10'd0,    1'b1, VAL_NONE, 1'b1},
		'{11'd2,    10'd1,    10'd1,    1'b1, VAL_NEG,  1'b0},
		'{11'd3,    10'd1,    10'd2,    1'b0, VAL_NONE, 1'b0},
		'{11'd3,    10'd2,    10'd2,    1'b1, VAL_NEG,  1'b0},
		'{11'd2047, 10'd1023, 10'd1023, 1'b1, VAL_NEG,  1'b0},
		'{11'd2047, 10'd0,    10'd1023, 1'b1, VAL_POS,  1'b0},
		'{11'd2047, 10'd1023, 10'd0,    1'b1, VAL_POS,  1'b0},
		'{11'd2047, 10'd5,    10'd700,  1'b0, VAL_NONE, 1'b0},
		'{11'd12,   10'd5,    10'd7,    1'b0, VAL_NONE, 1'b0},
		'{11'd12,   10'd11,   10'd11,   1'b1, VAL_NEG,  1'b0},
		'{11'd12,   10'd12,   10'd1,    1'b1, VAL_NONE, 1'b1},
		'{11'd12,   10'd3,    10'd1,    1'b0, VAL_NONE, 1'b0}
	};

	localparam int SEG_ORDERS [N_SEGMENTS] = '{
		8, 0, 12, 2047, 20, 1, 44, 1024, 68, 4, 108, 2, 252, 600
	};

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_we    = 1'b0;
	logic [ORDER_W-1:0] cfg_wdata = '0;

	// bench copy of the block state
	logic [ORDER_W-1:0] order_now = ORDER_RESET;
	bit                 residues_built;
	bit [MAX_ORDER-1:0] residue_bits;

	rsp_t entries_due [$];
	rsp_t want_rsp;
	int   mismatches;
	int   send_idle_pct;
	int   recv_stall_pct = 0;
	int   hold_calls     = 0;
	int   hold_seen      = 0;
	int   hold_left      = 0;
	int   quiet_cycles   = 0;

	paley_hadamard_entry_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int eff_order();
		return (order_now > ORDER_MAX) ? MAX_ORDER : int'(order_now);
	endfunction

	function automatic rsp_t entry_of(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
		rsp_t res;
		int   n;
		int   p;
		int   d;
		int   i;
		n = eff_order();
		if (int'(r) >= n || int'(c) >= n) begin
			res.entry_value = VAL_NONE;
			res.index_error = 1'b1;
			return res;
		end
		res.index_error = 1'b0;
		if (r == 0 || c == 0) begin
			res.entry_value = VAL_POS;
			return res;
		end
		p = n - 1;
		if (!residues_built) begin
			residue_bits = '0;
			for (i = 1; i <= (p - 1) / 2; i++)
				residue_bits[(i * i) % p] = 1'b1;
			residues_built = 1'b1;
		end
		d = (int'(c) + p - int'(r)) % p;
		res.entry_value = (d != 0 && residue_bits[d]) ? VAL_POS : VAL_NEG;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic send_request(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
			input bit typed, input rsp_t typed_rsp);
		req       <= {r, c};
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		entries_due.push_back(typed ? typed_rsp : entry_of(r, c));
	endtask

	task automatic idle_gap();
		int n;
		n = 0;
		while (n < 200 && $urandom_range(99) < send_idle_pct)
			n++;
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (entries_due.size() != 0)
			@(posedge clk);
	endtask

	// order writes only land with nothing in flight
	task automatic load_order(input logic [ORDER_W-1:0] v);
		req_valid <= 1'b0;
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we         <= 1'b0;
		order_now      = v;
		residues_built = 1'b0;
	endtask

	task automatic set_idling(input idle_mode_e mode);
		send_idle_pct  = (mode == IDLE_SENDER) ? 77 : (mode == IDLE_BOTH) ? 22 : 0;
		recv_stall_pct <= (mode == IDLE_RECEIVER) ? 77 : (mode == IDLE_BOTH) ? 22 : 0;
	endtask

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_calls) begin
			hold_seen <= hold_calls;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (entries_due.size() == 0) begin
				report_mismatch($sformatf("response %0d/%0d with no request outstanding",
					rsp.entry_value, rsp.index_error));
			end else begin
				want_rsp = entries_due.pop_front();
				if (rsp.entry_value !== want_rsp.entry_value)
					report_mismatch($sformatf("entry_value got %0d want %0d",
						rsp.entry_value, want_rsp.entry_value));
				if (rsp.index_error !== want_rsp.index_error)
					report_mismatch($sformatf("index_error got %0b want %0b",
						rsp.index_error, want_rsp.index_error));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int                 n;
		int                 k;
		int                 seg;
		int                 item;
		logic [IDX_W-1:0]   r;
		logic [IDX_W-1:0]   c;
		logic [ORDER_W-1:0] ord;
		rsp_t               known;

		mismatches     = 0;
		send_idle_pct  = 0;
		residues_built = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (PROBES[i]) begin
			if (PROBES[i].order != order_now)
				load_order(PROBES[i].order);
			known.entry_value = PROBES[i].value;
			known.index_error = PROBES[i].err;
			send_request(PROBES[i].row, PROBES[i].col, PROBES[i].typed, known);
		end

		// random segments, one order each
		for (seg = 0; seg < N_SEGMENTS; seg++) begin
			ord = (seg == 11) ? ORDER_W'($urandom_range(2047)) : ORDER_W'(SEG_ORDERS[seg]);
			load_order(ord);
			set_idling(idle_mode_e'(seg % 4));
			n = eff_order();
			for (item = 0; item < SEG_ITEMS; item++) begin
				if (seg == 4 && item == 10)
					hold_calls <= hold_calls + 1;
				if (seg == 6 && item == 25) begin
					req_valid <= 1'b0;
					wait_drained();
				end
				k = $urandom_range(99);
				r = IDX_W'($urandom_range(1023));
				c = IDX_W'($urandom_range(1023));
				if (n > 0 && k >= 15) begin
					r = IDX_W'($urandom_range(n - 1));
					c = IDX_W'($urandom_range(n - 1));
					if (k < 20)
						r = '0;
					else if (k < 25)
						c = '0;
					else if (k < 32)
						c = r;
					else if (k < 38)
						r = (n <= 1023 && $urandom_range(1)) ? IDX_W'(n) : IDX_W'(n - 1);
				end
				send_request(r, c, 1'b0, known);
				idle_gap();
			end
		end

		req_valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && entries_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
